// ----- rtl/orb_pkg.sv -----
// ----------------------------------------------------------------------------
// orb_pkg
// shared types, action codes and default sizes for the overwriting ring buffer
// ----------------------------------------------------------------------------
package orb_pkg;

  // fixed field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;

  // parameter defaults
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  // ring_size after reset
  localparam logic [CNT_W-1:0] RING_SIZE_RST = 5'd16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;      // word taken on the input channel this cycle
    logic load_rdata;  // capture the slot read into the result register
  } orb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;  // offered action is a pop or peek on a non-empty ring
  } orb_status_t;

endpackage

// ----- rtl/orb_ram.sv -----
// ----------------------------------------------------------------------------
// orb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module orb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/orb_datapath.sv -----
// ----------------------------------------------------------------------------
// orb_datapath
// pointers, fill count, slot ram and result register of the ring buffer
// ----------------------------------------------------------------------------
module orb_datapath import orb_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  orb_cmd_t          cmd_i,
  output orb_status_t       status_o,
  input  logic              ring_size_we_i,
  input  logic [CNT_W-1:0]  ring_size_i,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic              read_valid_o,
  output logic              overwrote_o,
  output logic [CNT_W-1:0]  drained_count_o,
  output logic [CNT_W-1:0]  fill_count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
  // largest capacity the register can ask for at this depth
  localparam logic [CNT_W-1:0] CAP_MAX = (DEPTH > 31) ? 5'd31 : CNT_W'(DEPTH);

  logic [CNT_W-1:0] ring_size_q;
  logic [PW-1:0]    start_q, start_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [CNT_W-1:0] cap;
  logic             full, empty;
  logic [SW-1:0]    start_inc, tail_sum, tail_wrap;
  logic [PW-1:0]    start_next, tail_addr;

  logic             ram_we, ram_re;
  logic [PW-1:0]    ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [WORD_WIDTH+DATA_W-1:0] wdata_ext;
  logic [DATA_W+WORD_WIDTH-1:0] rdata_ext;

  logic [DATA_W-1:0] rdata_q;
  logic              rvalid_q, rvalid_d;
  logic              over_q, over_d;
  logic [CNT_W-1:0]  drained_q, drained_d;
  logic [CNT_W-1:0]  fill_q;

  // effective capacity: zero counts as one, clipped to the built depth
  always_comb begin
    if (ring_size_q == '0) begin
      cap = CNT_W'(1);
    end else if (ring_size_q > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = ring_size_q;
    end
  end

  assign full  = (count_q == cap);
  assign empty = (count_q == '0);

  // start + 1 with wrap at the capacity
  assign start_inc  = SW'(start_q) + SW'(1);
  assign start_next = (start_inc >= SW'(cap)) ? '0 : start_inc[PW-1:0];

  // slot behind the newest entry
  assign tail_sum  = SW'(start_q) + SW'(count_q);
  assign tail_wrap = (tail_sum >= SW'(cap)) ? (tail_sum - SW'(cap)) : tail_sum;
  assign tail_addr = tail_wrap[PW-1:0];

  assign status_o.needs_read = (action_i inside {ACT_POP, ACT_PEEK}) && !empty;

  always_comb begin
    start_d   = start_q;
    count_d   = count_q;
    rvalid_d  = 1'b0;
    over_d    = 1'b0;
    drained_d = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = tail_addr;
    case (action_i)
      ACT_PUSH: begin
        ram_we = cmd_i.accept;
        if (full) begin
          ram_waddr = start_q;
          start_d   = start_next;
          over_d    = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (!empty) begin
          ram_re   = cmd_i.accept;
          rvalid_d = 1'b1;
          count_d  = count_q - CNT_W'(1);
          start_d  = start_next;
        end
      end
      ACT_PEEK: begin
        if (!empty) begin
          ram_re   = cmd_i.accept;
          rvalid_d = 1'b1;
        end
      end
      ACT_FLUSH: begin
        drained_d = count_q;
        count_d   = '0;
        start_d   = '0;
      end
      default: begin
        start_d = start_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= RING_SIZE_RST;
      start_q     <= '0;
      count_q     <= '0;
    end else if (ring_size_we_i) begin
      // a new capacity empties the ring
      ring_size_q <= ring_size_i;
      start_q     <= '0;
      count_q     <= '0;
    end else if (cmd_i.accept) begin
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  // word width may be narrower or wider than the port
  assign wdata_ext = {{WORD_WIDTH{1'b0}}, push_data_i};
  assign ram_wdata = wdata_ext[WORD_WIDTH-1:0];
  assign rdata_ext = {{DATA_W{1'b0}}, ram_rdata};

  orb_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (start_q),
    .rdata_o (ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rdata_q   <= '0;
      rvalid_q  <= rvalid_d;
      over_q    <= over_d;
      drained_q <= drained_d;
      fill_q    <= count_d;
    end else if (cmd_i.load_rdata) begin
      rdata_q <= rdata_ext[DATA_W-1:0];
    end
  end

  assign read_data_o     = rdata_q;
  assign read_valid_o    = rvalid_q;
  assign overwrote_o     = over_q;
  assign drained_count_o = drained_q;
  assign fill_count_o    = fill_q;

endmodule

// ----- rtl/orb_ctrl.sv -----
// ----------------------------------------------------------------------------
// orb_ctrl
// handshake controller: take a word, wait for a slot read when one is needed, hold the result
// ----------------------------------------------------------------------------
module orb_ctrl import orb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  orb_status_t status_i,
  output orb_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.accept     = accept;
  assign cmd_o.load_rdata = (state_q == S_READ);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = status_i.needs_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/overwriting_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// overwriting_ring_buffer
// ring buffer of words that overwrites its oldest entry when full
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one word: an action and
//   push data. push stores behind the newest entry, or over the oldest one
//   when the ring is full; pop returns and removes the oldest; peek returns
//   it in place; flush empties the ring and reports how many it held.
//   output channel (out_valid_o / out_ready_i) returns exactly one result
//   word per input word, always with the fill count after the action.
//   timing: push, flush and empty pop/peek show their result the cycle
//   after acceptance; a pop or peek that finds an entry first waits in a
//   read state for the registered read of the slot ram.
//   flow: one word at a time; the next word is taken once the current
//   result has been taken, so a receiver that holds off out_ready_i also
//   holds off the input channel.
//   ring_size_we_i writes the capacity (0 acts as 1, clipped to DEPTH) and
//   empties the ring; write it only while idle.
//   reset: ring empty, capacity 16; slot contents are undefined but never
//   read before written. a stalled receiver simply holds the result register.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer import orb_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // capacity register
  input  logic              ring_size_we_i,
  input  logic [CNT_W-1:0]  ring_size_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [DATA_W-1:0] push_data_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] read_data_o,
  output logic              read_valid_o,
  output logic              overwrote_o,
  output logic [CNT_W-1:0]  drained_count_o,
  output logic [CNT_W-1:0]  fill_count_o
);

  orb_cmd_t    cmd;
  orb_status_t status;

  // sequencing of one word at a time
  orb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // pointers, count, slot ram and the result register
  orb_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .ring_size_we_i  (ring_size_we_i),
    .ring_size_i     (ring_size_i),
    .action_i        (action_i),
    .push_data_i     (push_data_i),
    .read_data_o     (read_data_o),
    .read_valid_o    (read_valid_o),
    .overwrote_o     (overwrote_o),
    .drained_count_o (drained_count_o),
    .fill_count_o    (fill_count_o)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the overwriting ring buffer
// ----------------------------------------------------------------------------
// words are queued by the stimulus block and fed to the input channel by a
// driver on the falling edge. a monitor on the rising edge runs every
// accepted word through a behavioural ring model and compares each returned
// result, field by field, with the oldest prediction. the capacity register
// is rewritten between runs of words, once all results are back: the
// extremes, zero and an oversize value among the settings.
// ----------------------------------------------------------------------------
module testbench;
  import orb_pkg::*;

  localparam int unsigned RING_DEPTH  = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              valid;
    logic              over;
    logic [CNT_W-1:0]  drained;
    logic [CNT_W-1:0]  fill;
  } ring_result_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] data;
  } ring_word_t;

  // block ports, all inputs known from time zero
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              ring_size_we_i = 1'b0;
  logic [CNT_W-1:0]  ring_size_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [ACT_W-1:0]  action_i       = ACT_PUSH;
  logic [DATA_W-1:0] push_data_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [DATA_W-1:0] read_data_o;
  logic              read_valid_o;
  logic              overwrote_o;
  logic [CNT_W-1:0]  drained_count_o;
  logic [CNT_W-1:0]  fill_count_o;

  // word flow between stimulus, driver and monitor
  ring_word_t   pending_words [$];
  ring_result_t ring_expected [$];
  int unsigned  words_queued  = 0;
  int unsigned  results_seen  = 0;
  int unsigned  fail_count    = 0;
  int unsigned  cycle_count   = 0;
  logic         in_taken      = 1'b0;

  // idling percentages, changed by the stimulus between runs
  int unsigned sender_idle_pct   = 7;
  int unsigned receiver_idle_pct = 79;

  // shadow of the ring held by the predictor
  logic [DATA_W-1:0] ring_slots [RING_DEPTH];
  int unsigned       ring_start    = 0;
  int unsigned       ring_fill     = 0;
  logic [CNT_W-1:0]  ring_size_reg = RING_SIZE_RST;

  overwriting_ring_buffer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ring_size_we_i (ring_size_we_i),
    .ring_size_i    (ring_size_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .push_data_i    (push_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .overwrote_o    (overwrote_o),
    .drained_count_o(drained_count_o),
    .fill_count_o   (fill_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // ring predictor
  // --------------------------------------------------------------------------

  // effective capacity: zero behaves as one, anything past the depth is clipped
  function automatic int unsigned ring_cap();
    if (ring_size_reg == 0) return 1;
    if (ring_size_reg > RING_DEPTH) return RING_DEPTH;
    return ring_size_reg;
  endfunction

  function automatic int unsigned ring_next(int unsigned p, int unsigned cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  function automatic ring_result_t ring_predict(logic [ACT_W-1:0] act,
                                                logic [DATA_W-1:0] data);
    ring_result_t res;
    int unsigned  cap;
    int unsigned  slot;
    res = '{default: '0};
    cap = ring_cap();
    if (ring_start >= cap) ring_start = 0;
    if (ring_fill > cap) ring_fill = cap;
    case (act)
      ACT_PUSH: begin
        if (ring_fill == cap) begin
          // full: the oldest entry is replaced and the start moves on
          slot       = ring_start;
          ring_start = ring_next(ring_start, cap);
          res.over   = 1'b1;
        end else begin
          slot = ring_start + ring_fill;
          if (slot >= cap) slot -= cap;
          ring_fill++;
        end
        ring_slots[slot] = data;
      end
      ACT_POP, ACT_PEEK: begin
        // an empty ring leaves everything as it is
        if (ring_fill > 0) begin
          res.data  = ring_slots[ring_start];
          res.valid = 1'b1;
          if (act == ACT_POP) begin
            ring_fill--;
            ring_start = ring_next(ring_start, cap);
          end
        end
      end
      default: begin
        res.drained = CNT_W'(ring_fill);
        ring_fill   = 0;
        ring_start  = 0;
      end
    endcase
    res.fill = CNT_W'(ring_fill);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // driver: new word or idle on the falling edge, valid held until taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    ring_word_t w;
    if (in_valid_i && !in_taken) begin
      // hold the word until the block takes it
    end else if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      w = pending_words.pop_front();
      in_valid_i  <= 1'b1;
      action_i    <= w.action;
      push_data_i <= w.data;
    end else begin
      in_valid_i <= 1'b0;
    end
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: predict on input handshake, compare on output handshake
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [DATA_W-1:0] want_v,
                             logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    ring_result_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        ring_expected.push_back(ring_predict(action_i, push_data_i));
      if (out_valid_o && out_ready_i) begin
        if (ring_expected.size() == 0) begin
          $error("result word with no prediction outstanding");
          fail_count++;
        end else begin
          want = ring_expected.pop_front();
          check_field("read_data", want.data, read_data_o);
          check_field("read_valid", DATA_W'(want.valid), DATA_W'(read_valid_o));
          check_field("overwrote", DATA_W'(want.over), DATA_W'(overwrote_o));
          check_field("drained_count", DATA_W'(want.drained),
                      DATA_W'(drained_count_o));
          check_field("fill_count", DATA_W'(want.fill), DATA_W'(fill_count_o));
          results_seen++;
        end
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_word(logic [ACT_W-1:0] act, logic [DATA_W-1:0] data);
    ring_word_t w;
    w.action = act;
    w.data   = data;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // every queued word has had its result back
  task automatic wait_idle();
    do @(negedge clk_i); while (results_seen != words_queued);
  endtask

  // a capacity write also empties the ring
  task automatic set_ring_size(logic [CNT_W-1:0] size);
    wait_idle();
    ring_size_we_i <= 1'b1;
    ring_size_i    <= size;
    @(negedge clk_i);
    ring_size_we_i <= 1'b0;
    ring_size_reg = size;
    ring_start    = 0;
    ring_fill     = 0;
  endtask

  task automatic random_words(int unsigned count, int unsigned push_pct);
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] data;
    int unsigned       r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < push_pct) act = ACT_PUSH;
      else if (r >= 96) act = ACT_FLUSH;
      else act = ($urandom_range(2) == 0) ? ACT_PEEK : ACT_POP;
      case ($urandom_range(7))
        0:       data = '0;
        1:       data = '1;
        default: data = $urandom;
      endcase
      queue_word(act, data);
    end
  endtask

  initial begin : stimulus
    logic [CNT_W-1:0] run_sizes [9];
    run_sizes = '{5'd16, 5'd1, 5'd2, 5'd7, 5'd0, 5'd31, 5'd3, 5'd0, 5'd16};
    run_sizes[7] = CNT_W'($urandom_range(16, 1));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity: reads and flush on empty, then a short fill and drain
    queue_word(ACT_PEEK, 32'h1234_5678);
    queue_word(ACT_POP, '1);
    queue_word(ACT_FLUSH, '0);
    queue_word(ACT_PUSH, '0);
    queue_word(ACT_PUSH, '1);
    queue_word(ACT_PEEK, '0);
    queue_word(ACT_POP, '0);
    queue_word(ACT_POP, '0);
    queue_word(ACT_POP, '0);

    // capacity three: overwrite on full, flush with entries left
    set_ring_size(5'd3);
    queue_word(ACT_PUSH, 32'h5555_AAAA);
    queue_word(ACT_PUSH, 32'hAAAA_5555);
    queue_word(ACT_PUSH, 32'h0000_0001);
    queue_word(ACT_PUSH, 32'h8000_0000);
    queue_word(ACT_PEEK, '0);
    queue_word(ACT_POP, '0);
    queue_word(ACT_FLUSH, '0);
    queue_word(ACT_POP, '0);

    // zero acts as a single slot
    set_ring_size(5'd0);
    queue_word(ACT_PUSH, 32'h0000_0007);
    queue_word(ACT_PUSH, 32'h0000_0008);
    queue_word(ACT_POP, '0);

    // oversize value clipped to the depth
    set_ring_size(5'd31);
    queue_word(ACT_PUSH, 32'hDEAD_BEEF);
    queue_word(ACT_PUSH, 32'h0F0F_F0F0);
    queue_word(ACT_FLUSH, '0);

    // random runs, each at its own capacity and push bias
    for (int run = 0; run < 9; run++) begin
      set_ring_size(run_sizes[run]);
      if (run == 3) begin
        sender_idle_pct   = 79;
        receiver_idle_pct = 7;
      end else if (run == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      random_words(66, $urandom_range(85, 50));
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
